// ===== hw/rtl/aldk_pkg.sv =====
// Package: key codes, ladder band limits and shared types for the keypad decoder.
package aldk_pkg;

  localparam int unsigned SampleWidth = 10;
  localparam int unsigned CodeWidth   = 3;
  localparam int unsigned ReloadWidth = 16;

  localparam logic [ReloadWidth-1:0] ReloadReset = 16'd10;

  typedef enum logic [CodeWidth-1:0] {
    KeyNone  = 3'd0,
    KeyEnter = 3'd1,
    KeyBack  = 3'd2,
    KeyNext  = 3'd3,
    KeyPlus  = 3'd4,
    KeyMinus = 3'd5
  } key_code_e;

  // Open bands: low < sample < high
  localparam logic [SampleWidth:0] MinusLo = 11'd185;
  localparam logic [SampleWidth:0] MinusHi = 11'd225;
  localparam logic [SampleWidth:0] BackLo  = 11'd234;
  localparam logic [SampleWidth:0] BackHi  = 11'd274;
  localparam logic [SampleWidth:0] NextLo  = 11'd321;
  localparam logic [SampleWidth:0] NextHi  = 11'd361;
  localparam logic [SampleWidth:0] PlusLo  = 11'd492;
  localparam logic [SampleWidth:0] PlusHi  = 11'd532;
  localparam logic [SampleWidth:0] EnterLo = 11'd1003;
  localparam logic [SampleWidth:0] EnterHi = 11'd1024;

  typedef struct packed {
    logic [CodeWidth-1:0] stable_key;
    logic [CodeWidth-1:0] raw_key;
  } key_word_t;

  function automatic logic in_band(input logic [SampleWidth-1:0] s,
                                   input logic [SampleWidth:0]   lo,
                                   input logic [SampleWidth:0]   hi);
    logic [SampleWidth:0] sx;
    sx = {1'b0, s};
    return (sx > lo) && (sx < hi);
  endfunction

  // Later bands take priority; no match keeps the current code.
  function automatic logic [CodeWidth-1:0] classify(input logic [SampleWidth-1:0] s,
                                                    input logic [CodeWidth-1:0]   cur);
    logic [CodeWidth-1:0] code;
    code = cur;
    if (in_band(s, MinusLo, MinusHi)) code = KeyMinus;
    if (in_band(s, BackLo, BackHi))   code = KeyBack;
    if (in_band(s, NextLo, NextHi))   code = KeyNext;
    if (in_band(s, PlusLo, PlusHi))   code = KeyPlus;
    if (in_band(s, EnterLo, EnterHi)) code = KeyEnter;
    return code;
  endfunction

endpackage

// ===== hw/rtl/aldk_if.sv =====
// Interfaces: sample, key result and configuration channels.
interface aldk_sample_if;
  logic                                valid;
  logic                                ready;
  logic [aldk_pkg::SampleWidth-1:0]    adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface aldk_key_if;
  logic                                valid;
  logic                                ready;
  logic [aldk_pkg::CodeWidth-1:0]      stable_key;
  logic [aldk_pkg::CodeWidth-1:0]      raw_key;
  modport source (output valid, output stable_key, output raw_key, input ready);
  modport sink   (input valid, input stable_key, input raw_key, output ready);
endinterface

interface aldk_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [aldk_pkg::ReloadWidth-1:0]    debounce_reload;
  modport source (output valid, output debounce_reload, input ready);
  modport sink   (input valid, input debounce_reload, output ready);
endinterface

// ===== hw/rtl/aldk_core.sv =====
// Core: ladder classification, debounce counter and key state registers.
module aldk_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [aldk_pkg::SampleWidth-1:0] sample_i,
  input  logic                             cfg_we_i,
  input  logic [aldk_pkg::ReloadWidth-1:0] cfg_reload_i,
  output aldk_pkg::key_word_t              word_o
);

  logic [aldk_pkg::ReloadWidth-1:0] reload_q;
  logic [aldk_pkg::SampleWidth-1:0] prev_q;
  logic [aldk_pkg::CodeWidth-1:0]   sticky_q, sticky_d;
  logic [aldk_pkg::CodeWidth-1:0]   cand_q, cand_d;
  logic [aldk_pkg::ReloadWidth-1:0] hold_q, hold_d;
  logic [aldk_pkg::CodeWidth-1:0]   stable_q, stable_d;

  always_comb begin
    sticky_d = sticky_q;
    if (sample_i != prev_q) begin
      sticky_d = aldk_pkg::classify(sample_i, sticky_q);
    end
    cand_d = cand_q;
    hold_d = hold_q;
    if (cand_q == sticky_d) begin
      if (hold_q != '0) begin
        hold_d = hold_q - 1'b1;
      end
    end else begin
      hold_d = reload_q;
      cand_d = sticky_d;
    end
    stable_d = (hold_d == '0) ? cand_d : stable_q;
  end

  assign word_o.stable_key = stable_d;
  assign word_o.raw_key    = sticky_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= aldk_pkg::ReloadReset;
    end else if (cfg_we_i) begin
      reload_q <= cfg_reload_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      sticky_q <= aldk_pkg::KeyNone;
      cand_q   <= aldk_pkg::KeyNone;
      hold_q   <= '0;
      stable_q <= aldk_pkg::KeyNone;
    end else if (push_i) begin
      prev_q   <= sample_i;
      sticky_q <= sticky_d;
      cand_q   <= cand_d;
      hold_q   <= hold_d;
      stable_q <= stable_d;
    end
  end

  a_stable_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q == '0) |-> (stable_q == cand_q))
    else $error("stable key differs from candidate with counter at zero");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_i |=> ($stable(sticky_q) && $stable(hold_q) && $stable(stable_q)))
    else $error("key state moved without a sample");

  a_change_reloads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && (cand_q != sticky_d) && !cfg_we_i) |=> (hold_q == reload_q))
    else $error("code change did not reload the counter");

endmodule

// ===== hw/rtl/aldk_skid.sv =====
// Output buffer: result register plus skid entry so input stays open for one more word under stall.
module aldk_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  aldk_pkg::key_word_t word_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                pop_ready_i,
  output aldk_pkg::key_word_t word_o
);

  logic                main_valid_q, main_valid_d;
  logic                skid_valid_q, skid_valid_d;
  aldk_pkg::key_word_t main_q, main_d;
  aldk_pkg::key_word_t skid_q, skid_d;
  logic                pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign word_o  = main_q;
  assign pop     = main_valid_q && pop_ready_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q) begin
      main_valid_d = push_i;
      main_d       = word_i;
    end else if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        main_valid_d = push_i;
        main_d       = word_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry full with empty output register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("word pushed into full buffer");

  a_stall_keeps_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_valid_q && !pop_ready_i) |=> (main_valid_q && $stable(main_q)))
    else $error("stalled output word changed");

endmodule

// ===== hw/rtl/adc_ladder_keypad_debounce.sv =====
// Top level: resistor-ladder keypad decoder with debounce.
//
// sample_i carries one 10-bit ADC word per debounce tick. Each accepted word
// yields exactly one key word on key_o: stable_key (debounced) and raw_key
// (sticky classified code), 0 none, 1 enter, 2 back, 3 next, 4 plus, 5 minus.
// cfg_i writes debounce_reload (reset 10); ready is always high, write only
// while no words are in flight.
//
// Key words are built combinationally and registered in the output buffer; one
// word per cycle while the sink accepts. Classification and counter update
// are one compare set and one 16-bit decrement before the state registers.
//
// Reset clears all codes, the counter and the previous sample; stable_key is
// none until a key holds for the reload count. When the key sink stalls, a
// two-entry output buffer absorbs one more word; sample_i.ready then drops
// until the sink takes a word.
module adc_ladder_keypad_debounce (
  input  logic           clk_i,
  input  logic           rst_ni,
  aldk_sample_if.sink    sample_i,
  aldk_cfg_if.sink       cfg_i,
  aldk_key_if.source     key_o
);

  logic                push;
  logic                in_ready;
  aldk_pkg::key_word_t core_word;
  aldk_pkg::key_word_t out_word;

  assign sample_i.ready = in_ready;
  assign push           = sample_i.valid && in_ready;
  assign cfg_i.ready    = 1'b1;

  aldk_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .sample_i     (sample_i.adc_sample),
    .cfg_we_i     (cfg_i.valid),
    .cfg_reload_i (cfg_i.debounce_reload),
    .word_o       (core_word)
  );

  aldk_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .word_i      (core_word),
    .ready_o     (in_ready),
    .valid_o     (key_o.valid),
    .pop_ready_i (key_o.ready),
    .word_o      (out_word)
  );

  assign key_o.stable_key = out_word.stable_key;
  assign key_o.raw_key    = out_word.raw_key;

endmodule
